// File: rtl/dims_pkg.sv
`timescale 1ns / 1ps
package dims_pkg;

  localparam int DEPTH_W     = 17;
  localparam int SPREAD_W    = 16;
  localparam int COMP_W      = 21;
  localparam int VEC_W       = 63;
  localparam int SIZE_W      = 13;
  localparam int POINT_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int ROUND_SHIFT = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = 17'h10000;
  localparam logic [SIZE_W-1:0]  SIZE_MIN  = 13'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_ORIGIN    = 3'd2,
    REG_COL_STEP  = 3'd3,
    REG_ROW_STEP  = 3'd4,
    REG_DEPTH_VEC = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic acc;
    logic en1;
    logic en2;
    logic en_out;
  } pipe_ctl_t;

  function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] vec, input int k);
    comp = signed'(vec[k*COMP_W +: COMP_W]);
  endfunction

  function automatic logic [SPREAD_W-1:0] absdiff(input logic [SPREAD_W-1:0] a,
                                                  input logic [SPREAD_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SPREAD_W-1:0] max3(input logic [SPREAD_W-1:0] a,
                                               input logic [SPREAD_W-1:0] b,
                                               input logic [SPREAD_W-1:0] c);
    logic [SPREAD_W-1:0] m;
    m = (a > b) ? a : b;
    max3 = (m > c) ? m : c;
  endfunction

endpackage

// File: rtl/dims_if.sv
`timescale 1ns / 1ps
interface dims_in_if;
  logic                           valid;
  logic                           ready;
  logic [dims_pkg::DEPTH_W-1:0]   depth;

  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface dims_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dims_pkg::POINT_W-1:0]  point_x;
  logic signed [dims_pkg::POINT_W-1:0]  point_y;
  logic signed [dims_pkg::POINT_W-1:0]  point_z;
  logic                                 quad_done;
  logic [dims_pkg::SPREAD_W-1:0]        upper_triangle_spread;
  logic                                 upper_triangle_blank;
  logic [dims_pkg::SPREAD_W-1:0]        lower_triangle_spread;
  logic                                 lower_triangle_blank;
  logic                                 frame_end;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output quad_done, output upper_triangle_spread,
                  output upper_triangle_blank, output lower_triangle_spread,
                  output lower_triangle_blank, output frame_end, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input quad_done, input upper_triangle_spread,
                  input upper_triangle_blank, input lower_triangle_spread,
                  input lower_triangle_blank, input frame_end, output ready);
endinterface

interface dims_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dims_pkg::CFG_IDX_W-1:0]   index;
  logic [dims_pkg::VEC_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dims_line_store.sv
`timescale 1ns / 1ps
module dims_line_store #(
  parameter int MAX_WIDTH = 4096,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dims_pkg::pipe_ctl_t             ctl,
  input  logic [dims_pkg::DEPTH_W-1:0]    depth_in,
  input  logic [dims_pkg::SIZE_W-1:0]     reg_width,
  input  logic [dims_pkg::SIZE_W-1:0]     reg_height,
  output logic                            s1_valid,
  output logic [COL_W-1:0]                s1_col,
  output logic [dims_pkg::SIZE_W-1:0]     s1_row,
  output logic [dims_pkg::DEPTH_W-1:0]    s1_depth,
  output logic [dims_pkg::DEPTH_W-1:0]    s1_left,
  output logic [dims_pkg::DEPTH_W-1:0]    s1_above,
  output logic [dims_pkg::DEPTH_W-1:0]    s1_above_left,
  output logic                            s1_quad,
  output logic                            s1_frame_end
);

  localparam int WIDTH_W = COL_W + 1;
  localparam int ROW_W   = dims_pkg::SIZE_W;

  logic [dims_pkg::DEPTH_W-1:0] mem [MAX_WIDTH];

  logic [COL_W-1:0]             col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]             row_cnt_r, row_cnt_nxt;
  logic [dims_pkg::DEPTH_W-1:0] left_r;
  logic [dims_pkg::DEPTH_W-1:0] above_left_r;
  logic                         s1_valid_r;
  logic [COL_W-1:0]             s1_col_r;
  logic [ROW_W-1:0]             s1_row_r;
  logic [dims_pkg::DEPTH_W-1:0] s1_depth_r;
  logic [dims_pkg::DEPTH_W-1:0] s1_left_r;
  logic [dims_pkg::DEPTH_W-1:0] s1_above_r;
  logic                         s1_quad_r;
  logic                         s1_frame_end_r;

  logic [WIDTH_W-1:0]           width_eff;
  logic [ROW_W-1:0]             height_eff;
  logic [COL_W-1:0]             col;
  logic [ROW_W-1:0]             row;
  logic                         last_col;
  logic                         last_row;
  logic [dims_pkg::DEPTH_W-1:0] depth_c;

  always_comb begin
    if (reg_width < dims_pkg::SIZE_MIN) begin
      width_eff = WIDTH_W'(2);
    end else if (32'(reg_width) > 32'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = WIDTH_W'(reg_width);
    end
    height_eff = (reg_height < dims_pkg::SIZE_MIN) ? dims_pkg::SIZE_MIN : reg_height;

    if (32'(col_cnt_r) >= 32'(width_eff)) begin
      col = COL_W'(width_eff - WIDTH_W'(1));
    end else begin
      col = col_cnt_r;
    end
    if (row_cnt_r >= height_eff) begin
      row = height_eff - ROW_W'(1);
    end else begin
      row = row_cnt_r;
    end
    last_col = (32'(col) + 32'd1) >= 32'(width_eff);
    last_row = (32'(row) + 32'd1) >= 32'(height_eff);

    depth_c = (depth_in > dims_pkg::DEPTH_ONE) ? dims_pkg::DEPTH_ONE : depth_in;

    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : row + ROW_W'(1);
    end else begin
      col_cnt_nxt = col + COL_W'(1);
      row_cnt_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      s1_above_r <= mem[col];
      mem[col]   <= depth_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      left_r       <= '0;
      above_left_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (ctl.acc) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        left_r    <= depth_c;
      end
      if (s1_valid_r && ctl.en2) begin
        above_left_r <= s1_above_r;
      end
      if (ctl.en1) begin
        s1_valid_r <= ctl.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      s1_col_r       <= col;
      s1_row_r       <= row;
      s1_depth_r     <= depth_c;
      s1_left_r      <= left_r;
      s1_quad_r      <= (col != '0) && (row != '0);
      s1_frame_end_r <= last_col && last_row;
    end
  end

  assign s1_valid      = s1_valid_r;
  assign s1_col        = s1_col_r;
  assign s1_row        = s1_row_r;
  assign s1_depth      = s1_depth_r;
  assign s1_left       = s1_left_r;
  assign s1_above      = s1_above_r;
  assign s1_above_left = above_left_r;
  assign s1_quad       = s1_quad_r;
  assign s1_frame_end  = s1_frame_end_r;

  a_acc_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc |=> s1_valid_r)
    else $error("accepted item did not reach the read stage");

endmodule

// File: rtl/dims_spread.sv
`timescale 1ns / 1ps
module dims_spread (
  input  logic                            clk,
  input  dims_pkg::pipe_ctl_t             ctl,
  input  logic [dims_pkg::DEPTH_W-1:0]    s1_depth,
  input  logic [dims_pkg::DEPTH_W-1:0]    s1_left,
  input  logic [dims_pkg::DEPTH_W-1:0]    s1_above,
  input  logic [dims_pkg::DEPTH_W-1:0]    s1_above_left,
  input  logic                            s1_quad,
  output logic [dims_pkg::SPREAD_W-1:0]   s2_upper_spread,
  output logic                            s2_upper_blank,
  output logic [dims_pkg::SPREAD_W-1:0]   s2_lower_spread,
  output logic                            s2_lower_blank
);

  localparam int BG = dims_pkg::DEPTH_W - 1;
  localparam int SW = dims_pkg::SPREAD_W;

  logic [SW-1:0] up_spread_r, lo_spread_r;
  logic          up_blank_r, lo_blank_r;
  logic [SW-1:0] up_spread_nxt, lo_spread_nxt;
  logic          up_blank_nxt, lo_blank_nxt;
  logic          up_bg, lo_bg;
  logic [SW-1:0] d, l, a, al;

  always_comb begin
    d     = s1_depth[SW-1:0];
    l     = s1_left[SW-1:0];
    a     = s1_above[SW-1:0];
    al    = s1_above_left[SW-1:0];
    up_bg = s1_above_left[BG] || s1_left[BG] || s1_above[BG];
    lo_bg = s1_above[BG] || s1_left[BG] || s1_depth[BG];

    up_spread_nxt = '0;
    lo_spread_nxt = '0;
    up_blank_nxt  = 1'b0;
    lo_blank_nxt  = 1'b0;
    if (s1_quad) begin
      up_blank_nxt = up_bg;
      lo_blank_nxt = lo_bg;
      if (!up_bg) begin
        up_spread_nxt = dims_pkg::max3(dims_pkg::absdiff(al, a), dims_pkg::absdiff(a, l),
                                       dims_pkg::absdiff(al, l));
      end
      if (!lo_bg) begin
        lo_spread_nxt = dims_pkg::max3(dims_pkg::absdiff(a, d), dims_pkg::absdiff(d, l),
                                       dims_pkg::absdiff(l, a));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      up_spread_r <= up_spread_nxt;
      lo_spread_r <= lo_spread_nxt;
      up_blank_r  <= up_blank_nxt;
      lo_blank_r  <= lo_blank_nxt;
    end
  end

  assign s2_upper_spread = up_spread_r;
  assign s2_upper_blank  = up_blank_r;
  assign s2_lower_spread = lo_spread_r;
  assign s2_lower_blank  = lo_blank_r;

endmodule

// File: rtl/dims_point.sv
`timescale 1ns / 1ps
module dims_point #(
  parameter int MAX_WIDTH = 4096,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                                 clk,
  input  dims_pkg::pipe_ctl_t                  ctl,
  input  logic [COL_W-1:0]                     s1_col,
  input  logic [dims_pkg::SIZE_W-1:0]          s1_row,
  input  logic [dims_pkg::DEPTH_W-1:0]         s1_depth,
  input  logic [dims_pkg::VEC_W-1:0]           origin_vec,
  input  logic [dims_pkg::VEC_W-1:0]           col_step_vec,
  input  logic [dims_pkg::VEC_W-1:0]           row_step_vec,
  input  logic [dims_pkg::VEC_W-1:0]           depth_vec,
  output logic signed [dims_pkg::POINT_W-1:0]  point_x,
  output logic signed [dims_pkg::POINT_W-1:0]  point_y,
  output logic signed [dims_pkg::POINT_W-1:0]  point_z
);

  localparam int CW    = dims_pkg::COMP_W;
  localparam int PC_W  = COL_W + 1 + CW;
  localparam int PR_W  = dims_pkg::SIZE_W + 1 + CW;
  localparam int PD_W  = dims_pkg::DEPTH_W + 1 + CW;
  localparam int PCR_W = (PC_W > PR_W) ? PC_W : PR_W;
  localparam int SUM_W = PCR_W + 2;
  localparam int PW    = dims_pkg::POINT_W;

  localparam logic signed [PD_W-1:0]  HALF  = PD_W'(1) <<< (dims_pkg::ROUND_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] P_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] P_MIN = -P_MAX - SUM_W'(1);

  logic signed [PC_W-1:0] pc_r [3];
  logic signed [PR_W-1:0] pr_r [3];
  logic signed [PD_W-1:0] pd_r [3];
  logic signed [PW-1:0]   pt_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [PD_W-1:0]  rnd;
    logic signed [PD_W-1:0]  dterm;
    logic signed [SUM_W-1:0] sum;
    logic signed [PW-1:0]    pt_nxt;

    always_ff @(posedge clk) begin
      if (ctl.en2) begin
        pc_r[k] <= $signed({1'b0, s1_col}) * dims_pkg::comp(col_step_vec, k);
        pr_r[k] <= $signed({1'b0, s1_row}) * dims_pkg::comp(row_step_vec, k);
        pd_r[k] <= $signed({1'b0, s1_depth}) * dims_pkg::comp(depth_vec, k);
      end
    end

    always_comb begin
      rnd   = pd_r[k] + HALF;
      dterm = rnd >>> dims_pkg::ROUND_SHIFT;
      sum   = SUM_W'(dims_pkg::comp(origin_vec, k)) + SUM_W'(pc_r[k]) + SUM_W'(pr_r[k])
            + SUM_W'(dterm);
      if (sum > P_MAX) begin
        pt_nxt = P_MAX[PW-1:0];
      end else if (sum < P_MIN) begin
        pt_nxt = P_MIN[PW-1:0];
      end else begin
        pt_nxt = sum[PW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en_out) begin
        pt_r[k] <= pt_nxt;
      end
    end
  end

  assign point_x = pt_r[0];
  assign point_y = pt_r[1];
  assign point_z = pt_r[2];

endmodule

// File: rtl/depth_image_to_mesh_stream.sv
`timescale 1ns / 1ps
// Depth image to mesh stream. Depth pixels enter in raster order and each
// accepted item gives one result item: the pixel's world point and, once
// column and row are both nonzero, the spread or blank mark of the two
// triangles of the quad ending at that pixel. The block takes one item per
// clock while no result is held at the output. An item passes three register
// stages (line store read, multiply, sum and saturate into the output
// register); its result is offered there. A held result stalls the
// stages behind it. The line store sets the rate of one item per
// clock: it is a single-port memory of MAX_WIDTH 17-bit entries that is read
// and written once per pixel. It is not cleared after reset. Corners above
// are taken from it only from the second row after reset on, so do not let
// the width grow past the columns that the row above has stored.
// Write configuration only while no item is in flight.
module depth_image_to_mesh_stream #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  dims_in_if.sink           in_ch,
  dims_out_if.source        out_ch,
  dims_cfg_if.sink          cfg_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [dims_pkg::SIZE_W-1:0]  reg_width_r;
  logic [dims_pkg::SIZE_W-1:0]  reg_height_r;
  logic [dims_pkg::VEC_W-1:0]   origin_r;
  logic [dims_pkg::VEC_W-1:0]   col_step_r;
  logic [dims_pkg::VEC_W-1:0]   row_step_r;
  logic [dims_pkg::VEC_W-1:0]   depth_vec_r;

  dims_pkg::pipe_ctl_t          ctl;

  logic                         s1_valid;
  logic [COL_W-1:0]             s1_col;
  logic [dims_pkg::SIZE_W-1:0]  s1_row;
  logic [dims_pkg::DEPTH_W-1:0] s1_depth;
  logic [dims_pkg::DEPTH_W-1:0] s1_left;
  logic [dims_pkg::DEPTH_W-1:0] s1_above;
  logic [dims_pkg::DEPTH_W-1:0] s1_above_left;
  logic                         s1_quad;
  logic                         s1_frame_end;

  logic [dims_pkg::SPREAD_W-1:0] s2_upper_spread;
  logic                          s2_upper_blank;
  logic [dims_pkg::SPREAD_W-1:0] s2_lower_spread;
  logic                          s2_lower_blank;

  logic                          s2_valid_r;
  logic                          s2_quad_r;
  logic                          s2_frame_end_r;

  logic                          out_valid_r;
  logic                          out_quad_r;
  logic                          out_frame_end_r;
  logic [dims_pkg::SPREAD_W-1:0] out_upper_spread_r;
  logic                          out_upper_blank_r;
  logic [dims_pkg::SPREAD_W-1:0] out_lower_spread_r;
  logic                          out_lower_blank_r;

  always_comb begin
    ctl.en_out = !out_valid_r || out_ch.ready;
    ctl.en2    = !s2_valid_r || ctl.en_out;
    ctl.en1    = !s1_valid || ctl.en2;
    ctl.acc    = ctl.en1 && in_ch.valid;
  end

  assign in_ch.ready  = ctl.en1;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_width_r  <= dims_pkg::SIZE_MIN;
      reg_height_r <= dims_pkg::SIZE_MIN;
      origin_r     <= '0;
      col_step_r   <= '0;
      row_step_r   <= '0;
      depth_vec_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        dims_pkg::REG_WIDTH:     reg_width_r  <= cfg_ch.data[dims_pkg::SIZE_W-1:0];
        dims_pkg::REG_HEIGHT:    reg_height_r <= cfg_ch.data[dims_pkg::SIZE_W-1:0];
        dims_pkg::REG_ORIGIN:    origin_r     <= cfg_ch.data;
        dims_pkg::REG_COL_STEP:  col_step_r   <= cfg_ch.data;
        dims_pkg::REG_ROW_STEP:  row_step_r   <= cfg_ch.data;
        dims_pkg::REG_DEPTH_VEC: depth_vec_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  dims_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .depth_in      (in_ch.depth),
    .reg_width     (reg_width_r),
    .reg_height    (reg_height_r),
    .s1_valid      (s1_valid),
    .s1_col        (s1_col),
    .s1_row        (s1_row),
    .s1_depth      (s1_depth),
    .s1_left       (s1_left),
    .s1_above      (s1_above),
    .s1_above_left (s1_above_left),
    .s1_quad       (s1_quad),
    .s1_frame_end  (s1_frame_end)
  );

  dims_spread u_spread (
    .clk             (clk),
    .ctl             (ctl),
    .s1_depth        (s1_depth),
    .s1_left         (s1_left),
    .s1_above        (s1_above),
    .s1_above_left   (s1_above_left),
    .s1_quad         (s1_quad),
    .s2_upper_spread (s2_upper_spread),
    .s2_upper_blank  (s2_upper_blank),
    .s2_lower_spread (s2_lower_spread),
    .s2_lower_blank  (s2_lower_blank)
  );

  dims_point #(.MAX_WIDTH(MAX_WIDTH)) u_point (
    .clk          (clk),
    .ctl          (ctl),
    .s1_col       (s1_col),
    .s1_row       (s1_row),
    .s1_depth     (s1_depth),
    .origin_vec   (origin_r),
    .col_step_vec (col_step_r),
    .row_step_vec (row_step_r),
    .depth_vec    (depth_vec_r),
    .point_x      (out_ch.point_x),
    .point_y      (out_ch.point_y),
    .point_z      (out_ch.point_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.en2) begin
        s2_valid_r <= s1_valid;
      end
      if (ctl.en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      s2_quad_r      <= s1_quad;
      s2_frame_end_r <= s1_frame_end;
    end
    if (ctl.en_out) begin
      out_quad_r         <= s2_quad_r;
      out_frame_end_r    <= s2_frame_end_r;
      out_upper_spread_r <= s2_upper_spread;
      out_upper_blank_r  <= s2_upper_blank;
      out_lower_spread_r <= s2_lower_spread;
      out_lower_blank_r  <= s2_lower_blank;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.quad_done             = out_quad_r;
  assign out_ch.frame_end             = out_frame_end_r;
  assign out_ch.upper_triangle_spread = out_upper_spread_r;
  assign out_ch.upper_triangle_blank  = out_upper_blank_r;
  assign out_ch.lower_triangle_spread = out_lower_spread_r;
  assign out_ch.lower_triangle_blank  = out_lower_blank_r;

  a_frame_end_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_quad_r)
    else $error("frame end item without a quad");

  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_upper_blank_r || out_lower_blank_r) |->
      (!out_upper_blank_r || out_upper_spread_r == '0) &&
      (!out_lower_blank_r || out_lower_spread_r == '0))
    else $error("blank triangle carries a spread");

  a_no_quad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_quad_r |->
      !out_upper_blank_r && !out_lower_blank_r &&
      out_upper_spread_r == '0 && out_lower_spread_r == '0)
    else $error("triangle fields set without a quad");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int LINE_DEPTH     = 4096;
  localparam int PIPE_LATENCY   = 3;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int WIDE_ROW_ITEMS = 300;

  localparam logic [dims_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [dims_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [dims_pkg::COMP_W-1:0]    COMP_MAX     = 21'h0FFFFF;
  localparam logic [dims_pkg::COMP_W-1:0]    COMP_MIN     = 21'h100000;
  localparam logic [dims_pkg::COMP_W-1:0]    COMP_NEG_ONE = 21'h1FFFFF;
  localparam logic [dims_pkg::SIZE_W-1:0]    SIZE_TOP     = 13'h1FFF;
  localparam longint                         POINT_HI     = 64'sd2147483647;
  localparam longint                         POINT_LO     = -64'sd2147483648;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_LIGHT, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic signed [dims_pkg::POINT_W-1:0] point_x;
    logic signed [dims_pkg::POINT_W-1:0] point_y;
    logic signed [dims_pkg::POINT_W-1:0] point_z;
    logic                                quad_done;
    logic [dims_pkg::SPREAD_W-1:0]       upper_triangle_spread;
    logic                                upper_triangle_blank;
    logic [dims_pkg::SPREAD_W-1:0]       lower_triangle_spread;
    logic                                lower_triangle_blank;
    logic                                frame_end;
  } mesh_vertex_t;

  logic clk;
  logic rst_n;

  dims_in_if  in_ch();
  dims_out_if out_ch();
  dims_cfg_if cfg_ch();

  depth_image_to_mesh_stream #(.MAX_WIDTH(LINE_DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [dims_pkg::SIZE_W-1:0]  cur_width;
  logic [dims_pkg::SIZE_W-1:0]  cur_height;
  logic [dims_pkg::VEC_W-1:0]   cur_vec [4];
  int                           col_pos;
  int                           row_pos;
  logic [dims_pkg::DEPTH_W-1:0] line_depth [LINE_DEPTH];
  bit                           line_written [LINE_DEPTH];
  logic [dims_pkg::DEPTH_W-1:0] left_px;
  logic [dims_pkg::DEPTH_W-1:0] above_left_px;

  mesh_vertex_t pending_vertices [$];
  int           errors = 0;
  int           burst_left = 0;
  bit           sender_calm = 1'b0;
  int           terrain = 32768;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic void reset_predictor();
    int i;
    cur_width = dims_pkg::SIZE_MIN;
    cur_height = dims_pkg::SIZE_MIN;
    for (i = 0; i < 4; i++) cur_vec[i] = '0;
    col_pos = 0;
    row_pos = 0;
    for (i = 0; i < LINE_DEPTH; i++) begin
      line_depth[i] = '0;
      line_written[i] = 1'b0;
    end
    left_px = '0;
    above_left_px = '0;
  endfunction

  function automatic int active_width();
    if (cur_width < dims_pkg::SIZE_MIN) return int'(dims_pkg::SIZE_MIN);
    if (int'(cur_width) > LINE_DEPTH) return LINE_DEPTH;
    return int'(cur_width);
  endfunction

  function automatic int active_height();
    if (cur_height < dims_pkg::SIZE_MIN) return int'(dims_pkg::SIZE_MIN);
    return int'(cur_height);
  endfunction

  function automatic int line_extent();
    int n;
    n = 0;
    while (n < LINE_DEPTH && line_written[n]) n++;
    return n;
  endfunction

  function automatic longint component_of(input logic [dims_pkg::VEC_W-1:0] vec, input int k);
    logic signed [dims_pkg::COMP_W-1:0] c;
    c = vec[k*dims_pkg::COMP_W +: dims_pkg::COMP_W];
    return longint'(c);
  endfunction

  function automatic logic signed [dims_pkg::POINT_W-1:0] saturate_point(input longint s);
    longint c;
    c = s;
    if (c > POINT_HI) c = POINT_HI;
    if (c < POINT_LO) c = POINT_LO;
    return c[dims_pkg::POINT_W-1:0];
  endfunction

  function automatic logic [dims_pkg::SPREAD_W-1:0] widest_gap(input int a, input int b,
                                                               input int c);
    int g1, g2, g3, m;
    g1 = (a > b) ? a - b : b - a;
    g2 = (b > c) ? b - c : c - b;
    g3 = (a > c) ? a - c : c - a;
    m = (g1 > g2) ? g1 : g2;
    m = (m > g3) ? m : g3;
    return m[dims_pkg::SPREAD_W-1:0];
  endfunction

  // Predict the vertex of one pixel and advance the raster position.
  function automatic mesh_vertex_t unproject_pixel(input logic [dims_pkg::DEPTH_W-1:0] raw);
    mesh_vertex_t v;
    longint acc [3];
    int w, h, col, row, k;
    logic [dims_pkg::DEPTH_W-1:0] d, above, above_left, left;
    bit last_col, last_row;
    w = active_width();
    h = active_height();
    d = (raw > dims_pkg::DEPTH_ONE) ? dims_pkg::DEPTH_ONE : raw;
    col = (col_pos >= w) ? w - 1 : col_pos;
    row = (row_pos >= h) ? h - 1 : row_pos;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    for (k = 0; k < 3; k++) begin
      acc[k] = component_of(cur_vec[0], k)
             + longint'(col) * component_of(cur_vec[1], k)
             + longint'(row) * component_of(cur_vec[2], k)
             + ((longint'(d) * component_of(cur_vec[3], k) + 64'sd32768)
                >>> dims_pkg::ROUND_SHIFT);
    end
    v.point_x = saturate_point(acc[0]);
    v.point_y = saturate_point(acc[1]);
    v.point_z = saturate_point(acc[2]);
    above = line_depth[col];
    above_left = above_left_px;
    left = left_px;
    v.quad_done = (col != 0) && (row != 0);
    v.upper_triangle_spread = '0;
    v.upper_triangle_blank = 1'b0;
    v.lower_triangle_spread = '0;
    v.lower_triangle_blank = 1'b0;
    if (v.quad_done) begin
      if (above_left >= dims_pkg::DEPTH_ONE || left >= dims_pkg::DEPTH_ONE ||
          above >= dims_pkg::DEPTH_ONE)
        v.upper_triangle_blank = 1'b1;
      else
        v.upper_triangle_spread = widest_gap(int'(above_left), int'(above), int'(left));
      if (above >= dims_pkg::DEPTH_ONE || left >= dims_pkg::DEPTH_ONE ||
          d >= dims_pkg::DEPTH_ONE)
        v.lower_triangle_blank = 1'b1;
      else
        v.lower_triangle_spread = widest_gap(int'(above), int'(d), int'(left));
    end
    v.frame_end = last_col && last_row;
    line_depth[col] = d;
    line_written[col] = 1'b1;
    above_left_px = above;
    left_px = d;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    return v;
  endfunction

  function automatic logic [dims_pkg::VEC_W-1:0] pack3(input logic [dims_pkg::COMP_W-1:0] x,
                                                       input logic [dims_pkg::COMP_W-1:0] y,
                                                       input logic [dims_pkg::COMP_W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [dims_pkg::COMP_W-1:0] random_component();
    int r;
    int t;
    logic [31:0] raw;
    logic signed [dims_pkg::COMP_W-1:0] s;
    r = int'($urandom_range(0, 9));
    raw = $urandom;
    if (r < 6) return raw[dims_pkg::COMP_W-1:0];
    if (r < 8) begin
      t = int'(raw[11:0]) - 2048;
      s = t[dims_pkg::COMP_W-1:0];
      return s;
    end
    if (r == 8) return COMP_MAX;
    return COMP_MIN;
  endfunction

  function automatic logic [dims_pkg::VEC_W-1:0] random_vector();
    return pack3(random_component(), random_component(), random_component());
  endfunction

  function automatic logic [dims_pkg::VEC_W-1:0] junk_with_size(input int size);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1) != 0) junk = '0;
    junk[dims_pkg::SIZE_W-1:0] = size[dims_pkg::SIZE_W-1:0];
    return junk[dims_pkg::VEC_W-1:0];
  endfunction

  // Mostly a smooth surface, with background holes and wild pixels.
  function automatic logic [dims_pkg::DEPTH_W-1:0] next_depth();
    int r;
    logic [31:0] raw;
    r = int'($urandom_range(0, 99));
    raw = $urandom;
    if (r < 3) return dims_pkg::DEPTH_ONE;
    if (r < 7) begin
      raw = $urandom_range(65537, 131071);
      return raw[dims_pkg::DEPTH_W-1:0];
    end
    if (r < 12) return raw[dims_pkg::DEPTH_W-1:0];
    if (r < 15) terrain = int'($urandom_range(0, 65535));
    terrain += int'($urandom_range(0, 512)) - 256;
    if (terrain < 0) terrain = 0;
    if (terrain > 65535) terrain = 65535;
    return terrain[dims_pkg::DEPTH_W-1:0];
  endfunction

  function automatic void check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_vertices
    mesh_vertex_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: vertex expected none, got point_x %0d", $time, out_ch.point_x);
        errors++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("point_x", longint'(want.point_x), longint'(out_ch.point_x));
        check_field("point_y", longint'(want.point_y), longint'(out_ch.point_y));
        check_field("point_z", longint'(want.point_z), longint'(out_ch.point_z));
        check_field("quad_done", longint'(want.quad_done), longint'(out_ch.quad_done));
        check_field("upper_triangle_spread", longint'(want.upper_triangle_spread),
                    longint'(out_ch.upper_triangle_spread));
        check_field("upper_triangle_blank", longint'(want.upper_triangle_blank),
                    longint'(out_ch.upper_triangle_blank));
        check_field("lower_triangle_spread", longint'(want.lower_triangle_spread),
                    longint'(out_ch.lower_triangle_spread));
        check_field("lower_triangle_blank", longint'(want.lower_triangle_blank),
                    longint'(out_ch.lower_triangle_blank));
        check_field("frame_end", longint'(want.frame_end), longint'(out_ch.frame_end));
      end
    end
  end

  initial begin : result_stalls
    stall_mode_t mode;
    int span, tick;
    out_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = int'($urandom_range(20, 200));
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          STALL_NONE: out_ch.ready <= 1'b1;
          STALL_COIN: out_ch.ready <= ($urandom_range(0, 1) != 0);
          STALL_LIGHT: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  task automatic send_depth(input logic [dims_pkg::DEPTH_W-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 24));
      gap = (sender_calm || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.depth <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_vertices.push_back(unproject_pixel(raw));
  endtask

  // Hold off until every vertex is out and the pipeline is empty.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dims_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dims_pkg::VEC_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      dims_pkg::REG_WIDTH: cur_width = data[dims_pkg::SIZE_W-1:0];
      dims_pkg::REG_HEIGHT: cur_height = data[dims_pkg::SIZE_W-1:0];
      dims_pkg::REG_ORIGIN: cur_vec[0] = data;
      dims_pkg::REG_COL_STEP: cur_vec[1] = data;
      dims_pkg::REG_ROW_STEP: cur_vec[2] = data;
      dims_pkg::REG_DEPTH_VEC: cur_vec[3] = data;
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_depth(next_depth());
  endtask

  task automatic test_reset_state();
    send_depth(17'd0);
    send_depth(17'd65535);
    send_depth(17'd100);
    send_depth(17'h1FFFF);
    drain_results();
  endtask

  task automatic test_directed_corners();
    write_reg(dims_pkg::REG_WIDTH, 63'd3);
    write_reg(dims_pkg::REG_HEIGHT, 63'd2);
    write_reg(dims_pkg::REG_ORIGIN, pack3(COMP_MAX, COMP_MIN, '0));
    write_reg(dims_pkg::REG_COL_STEP, pack3(21'd1, COMP_NEG_ONE, COMP_MAX));
    write_reg(dims_pkg::REG_ROW_STEP, pack3(COMP_MIN, 21'd1, 21'd7));
    write_reg(dims_pkg::REG_DEPTH_VEC, pack3(COMP_MAX, COMP_MIN, 21'd1));
    write_reg(REG_SPARE_LO, random_vector());
    write_reg(REG_SPARE_HI, random_vector());
    close_cfg();
    send_depth(17'd0);
    send_depth(17'd65535);
    send_depth(17'd32768);
    send_depth(17'd1);
    send_depth(17'd65534);
    send_depth(17'd65536);
    drain_results();
    // out-of-range sizes clamp to the minimum
    write_reg(dims_pkg::REG_WIDTH, junk_with_size(1));
    write_reg(dims_pkg::REG_HEIGHT, junk_with_size(0));
    write_reg(dims_pkg::REG_DEPTH_VEC, pack3(COMP_MIN, COMP_MAX, COMP_NEG_ONE));
    close_cfg();
    send_depth(17'h1FFFF);
    send_depth(17'd0);
    send_depth(17'd65535);
    send_depth(17'h18000);
    drain_results();
  endtask

  task automatic test_random_frames();
    int sent, n, w, h, r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      if ($urandom_range(0, 1) != 0) begin
        r = int'($urandom_range(0, 99));
        if (r < 6) w = int'($urandom_range(0, 1));
        else if (r < 85) w = int'($urandom_range(2, 8));
        else w = int'($urandom_range(9, 40));
        // never grow past the filled part of the line store below row zero
        if (row_pos == 0 || (w < 2 ? 2 : w) <= line_extent())
          write_reg(dims_pkg::REG_WIDTH, junk_with_size(w));
      end
      if ($urandom_range(0, 1) != 0) begin
        r = int'($urandom_range(0, 99));
        if (r < 6) h = int'($urandom_range(0, 1));
        else if (r < 90) h = int'($urandom_range(2, 6));
        else h = int'($urandom_range(7, 20));
        write_reg(dims_pkg::REG_HEIGHT, junk_with_size(h));
      end
      if ($urandom_range(0, 4) < 2) write_reg(dims_pkg::REG_ORIGIN, random_vector());
      if ($urandom_range(0, 4) < 2) write_reg(dims_pkg::REG_COL_STEP, random_vector());
      if ($urandom_range(0, 4) < 2) write_reg(dims_pkg::REG_ROW_STEP, random_vector());
      if ($urandom_range(0, 4) < 2) write_reg(dims_pkg::REG_DEPTH_VEC, random_vector());
      if ($urandom_range(0, 19) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                  random_vector());
      close_cfg();
      sender_calm = ($urandom_range(0, 4) == 0);
      n = int'($urandom_range(1, 3 * active_width() * active_height()));
      if (n > 150) n = 150;
      repeat (n) send_depth(next_depth());
      sent += n;
    end
    sender_calm = 1'b0;
    drain_results();
  endtask

  task automatic test_widest_row();
    write_reg(dims_pkg::REG_WIDTH, 63'd2);
    write_reg(dims_pkg::REG_HEIGHT, 63'd2);
    close_cfg();
    finish_frame();
    drain_results();
    write_reg(dims_pkg::REG_WIDTH, junk_with_size(int'(SIZE_TOP)));
    write_reg(dims_pkg::REG_COL_STEP, pack3(COMP_MAX, COMP_MIN, random_component()));
    write_reg(dims_pkg::REG_ROW_STEP, random_vector());
    write_reg(dims_pkg::REG_DEPTH_VEC, random_vector());
    close_cfg();
    sender_calm = 1'b1;
    repeat (WIDE_ROW_ITEMS) send_depth(next_depth());
    drain_results();
    // shrink mid-row: the column counter is past the new last index
    write_reg(dims_pkg::REG_WIDTH, 63'd6);
    close_cfg();
    sender_calm = 1'b0;
    repeat (8) send_depth(next_depth());
    drain_results();
  endtask

  task automatic test_tallest_frame();
    write_reg(dims_pkg::REG_WIDTH, 63'd2);
    write_reg(dims_pkg::REG_HEIGHT, 63'd2);
    close_cfg();
    finish_frame();
    drain_results();
    write_reg(dims_pkg::REG_HEIGHT, junk_with_size(int'(SIZE_TOP)));
    write_reg(dims_pkg::REG_ROW_STEP, pack3(COMP_MAX, COMP_MIN, COMP_NEG_ONE));
    close_cfg();
    repeat (120) send_depth(next_depth());
    drain_results();
    // shrink mid-frame: the row counter is past the new last row
    write_reg(dims_pkg::REG_HEIGHT, 63'd4);
    close_cfg();
    repeat (4) send_depth(next_depth());
    drain_results();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.depth <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= dims_pkg::REG_WIDTH;
    cfg_ch.data <= '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_corners();
    test_random_frames();
    test_widest_row();
    test_tallest_frame();
    drain_results();
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: depth_image_to_mesh_stream.f
rtl/dims_pkg.sv
rtl/dims_if.sv
rtl/dims_line_store.sv
rtl/dims_spread.sv
rtl/dims_point.sv
rtl/depth_image_to_mesh_stream.sv
bench/tb_top.sv
